>>> sv/cld_pkg.sv
// Package for the Content-Length message deframer.
// Holds line-scan codes, result kinds, character codes and the key text.
// No dependencies; cld_line_step, the core and the bench import it.
package cld_pkg;

	// key scan status
	localparam logic [1:0] KS_MATCH = 2'd0;
	localparam logic [1:0] KS_VALUE = 2'd1;
	localparam logic [1:0] KS_DEAD  = 2'd2;

	// value scan status
	localparam logic [2:0] VS_LEAD   = 3'd0;
	localparam logic [2:0] VS_SIGN   = 3'd1;
	localparam logic [2:0] VS_DIGITS = 3'd2;
	localparam logic [2:0] VS_TRAIL  = 3'd3;
	localparam logic [2:0] VS_FAIL   = 3'd4;

	// result kinds
	localparam logic [2:0] RK_BODY        = 3'd0;
	localparam logic [2:0] RK_EMPTY       = 3'd1;
	localparam logic [2:0] RK_NO_LENGTH   = 3'd2;
	localparam logic [2:0] RK_TRUNC_HDR   = 3'd3;
	localparam logic [2:0] RK_TRUNC_BODY  = 3'd4;

	// input beat kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] KEY_LEN = 4'd14;

	// per-line scan state, without the value accumulator
	typedef struct packed {
		logic [3:0] key_pos;
		logic [1:0] key_status;
		logic [2:0] value_status;
		logic       value_negative;
	} line_ctl_t;

	localparam line_ctl_t LINE_CLEAR = '{
		key_pos: 4'd0,
		key_status: KS_MATCH,
		value_status: VS_LEAD,
		value_negative: 1'b0
	};

	// "Content-Length", one character per key position
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> sv/cld_feed_if.sv
// Input channel of the deframer: one stream byte or end-of-input mark per beat.
// Standalone; no package needed.
interface cld_feed_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source (output valid, kind, in_byte, input ready);
	modport sink   (input valid, kind, in_byte, output ready);
endinterface

>>> sv/cld_result_if.sv
// Result channel of the deframer: body bytes and status results, one per beat.
// Standalone; no package needed.
interface cld_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] result_kind;
	logic [7:0] out_byte;
	logic       last_of_message;

	modport source (output valid, result_kind, out_byte, last_of_message, input ready);
	modport sink   (input valid, result_kind, out_byte, last_of_message, output ready);
endinterface

>>> sv/cld_line_step.sv
// One character step of the header line scanner: key match and value parse.
// Depends on cld_pkg for codes and the key text.
module cld_line_step #(
	parameter int LENGTH_BITS = 31
) (
	input  cld_pkg::line_ctl_t     cur,
	input  logic [LENGTH_BITS-1:0] acc,
	input  logic [7:0]             ch,
	output cld_pkg::line_ctl_t     nxt,
	output logic [LENGTH_BITS-1:0] acc_nxt
);
	import cld_pkg::*;

	localparam int PW = LENGTH_BITS + 4;

	logic          digit;
	logic          blank;
	logic [PW-1:0] prod;
	logic          over;

	assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign blank = (ch == CH_SPACE) || (ch == CH_TAB);
	// acc * 10 + digit as two shifts and adds
	assign prod  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{LENGTH_BITS{1'b0}}, ch[3:0]};
	assign over  = |prod[PW-1:LENGTH_BITS];

	always_comb begin
		nxt     = cur;
		acc_nxt = acc;
		unique case (cur.key_status)
			KS_MATCH: begin
				if (cur.key_pos >= KEY_LEN) begin
					nxt.key_status = (ch == CH_COLON) ? KS_VALUE : KS_DEAD;
				end else if (ch == key_char(cur.key_pos)) begin
					nxt.key_pos = cur.key_pos + 4'd1;
				end else begin
					nxt.key_status = KS_DEAD;
				end
			end
			KS_VALUE: begin
				unique case (cur.value_status)
					VS_LEAD: begin
						if (blank || ch == CH_VT || ch == CH_FF || ch == CH_CR) begin
							nxt.value_status = VS_LEAD;
						end else if (ch == CH_PLUS) begin
							nxt.value_status = VS_SIGN;
						end else if (ch == CH_MINUS) begin
							nxt.value_negative = 1'b1;
							nxt.value_status   = VS_SIGN;
						end else if (digit) begin
							nxt.value_status = over ? VS_FAIL : VS_DIGITS;
							if (!over) acc_nxt = prod[LENGTH_BITS-1:0];
						end else begin
							nxt.value_status = VS_FAIL;
						end
					end
					VS_SIGN, VS_DIGITS: begin
						if (digit) begin
							nxt.value_status = over ? VS_FAIL : VS_DIGITS;
							if (!over) acc_nxt = prod[LENGTH_BITS-1:0];
						end else if (blank && cur.value_status == VS_DIGITS) begin
							nxt.value_status = VS_TRAIL;
						end else begin
							nxt.value_status = VS_FAIL;
						end
					end
					VS_TRAIL: begin
						if (!blank) nxt.value_status = VS_FAIL;
					end
					default: nxt.value_status = VS_FAIL;
				endcase
			end
			default: begin
				// dead key: ignore the rest of the line
				nxt = cur;
			end
		endcase
	end

endmodule

>>> sv/content_length_message_deframer_core.sv
// Content-Length message deframer, top level.
// Depends on cld_pkg, cld_feed_if, cld_result_if and cld_line_step.
//
// Usage:
//   feed   : valid/ready channel, one beat per stream byte (kind 0) or an
//            end-of-input mark (kind 1).
//   result : valid/ready channel, zero or one beat per feed beat: body bytes
//            with last_of_message on the final one, or a status kind (empty
//            message, missing length, truncated header, truncated body).
// Timing: a feed beat accepted lands in the input register; its result, if any,
//   is then presented from the result register.
// Throughput: one feed beat per cycle while result is not held off. The header scan state is
//   updated in one pass per beat (two chained line-scan steps and a
//   times-ten add), which is the loop that sets that figure.
// Reset: the block starts in the header phase with an empty header; no
//   clearing pass. After an end-of-input mark the block stops and silently
//   drops every further beat until reset.
// Stall: while result is held off, the result register holds its beat, the
//   input register holds the next one, and feed.ready drops once both are
//   full.
module content_length_message_deframer_core #(
	parameter int LENGTH_BITS = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	cld_feed_if.sink      feed,
	cld_result_if.source  result
);
	import cld_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_STOP   = 2'd2;

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	logic [2:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// deframer state
	logic [1:0]             phase_q;
	logic [1:0]             delim_q;
	logic                   has_bytes_q;
	logic                   pend_cr_q;
	line_ctl_t              line_q;
	logic [LENGTH_BITS-1:0] acc_q;
	logic                   len_valid_q;
	logic [LENGTH_BITS-1:0] len_found_q;
	logic [LENGTH_BITS-1:0] remain_q;

	// next state
	logic [1:0]             phase_d;
	logic [1:0]             delim_d;
	logic                   has_bytes_d;
	logic                   pend_cr_d;
	line_ctl_t              line_d;
	logic [LENGTH_BITS-1:0] acc_d;
	logic                   len_valid_d;
	logic [LENGTH_BITS-1:0] len_found_d;
	logic [LENGTH_BITS-1:0] remain_d;
	logic                   emit;
	logic [2:0]             emit_kind;
	logic                   emit_last;

	// line-scan chain: a held CR first, then the current byte
	line_ctl_t              line_cr;
	logic [LENGTH_BITS-1:0] acc_cr;
	line_ctl_t              line_mid;
	logic [LENGTH_BITS-1:0] acc_mid;
	line_ctl_t              line_ch;
	logic [LENGTH_BITS-1:0] acc_ch;

	logic                   advance;
	logic                   work;
	logic                   line_ok;
	logic                   done;
	logic [LENGTH_BITS-1:0] remain_dec;

	// the result register frees up when empty or when its beat is taken
	assign advance      = !out_valid_q || result.ready;
	assign work         = valid_s1 && advance;
	assign feed.ready   = !valid_s1 || advance;

	assign result.valid           = out_valid_q;
	assign result.result_kind     = out_kind_q;
	assign result.out_byte        = out_byte_q;
	assign result.last_of_message = out_last_q;

	cld_line_step #(.LENGTH_BITS(LENGTH_BITS)) u_step_cr (
		.cur     (line_q),
		.acc     (acc_q),
		.ch      (CH_CR),
		.nxt     (line_cr),
		.acc_nxt (acc_cr)
	);

	assign line_mid = pend_cr_q ? line_cr : line_q;
	assign acc_mid  = pend_cr_q ? acc_cr  : acc_q;

	cld_line_step #(.LENGTH_BITS(LENGTH_BITS)) u_step_ch (
		.cur     (line_mid),
		.acc     (acc_mid),
		.ch      (byte_s1),
		.nxt     (line_ch),
		.acc_nxt (acc_ch)
	);

	// a finished line carries a usable length
	assign line_ok = (line_q.key_status == KS_VALUE) &&
		((line_q.value_status == VS_DIGITS) || (line_q.value_status == VS_TRAIL)) &&
		!(line_q.value_negative && (acc_q != '0));

	// LF closes the header after an empty line
	assign done = (!pend_cr_q && (delim_q != 2'd0)) || (pend_cr_q && (delim_q == 2'd1));

	assign remain_dec = (remain_q == '0) ? '0 : remain_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d     = phase_q;
		delim_d     = delim_q;
		has_bytes_d = has_bytes_q;
		pend_cr_d   = pend_cr_q;
		line_d      = line_q;
		acc_d       = acc_q;
		len_valid_d = len_valid_q;
		len_found_d = len_found_q;
		remain_d    = remain_q;
		emit        = 1'b0;
		emit_kind   = RK_BODY;
		emit_last   = 1'b0;

		if (phase_q == PH_HEADER || phase_q == PH_BODY) begin
			if (kind_s1 == KIND_END) begin
				// end of input: report truncation if a message is under way, and stop for good
				phase_d   = PH_STOP;
				if (phase_q == PH_BODY) begin
					emit      = 1'b1;
					emit_kind = RK_TRUNC_BODY;
				end else if (has_bytes_q) begin
					emit      = 1'b1;
					emit_kind = RK_TRUNC_HDR;
				end
			end else if (phase_q == PH_BODY) begin
				// pass the body byte through, mark the last one
				remain_d  = remain_dec;
				emit      = 1'b1;
				emit_kind = RK_BODY;
				if (remain_dec == '0) begin
					emit_last = 1'b1;
					phase_d   = PH_HEADER;
				end
			end else begin
				has_bytes_d = 1'b1;
				if (byte_s1 == CH_LF) begin
					// close the line, keep its length if it parsed
					if (line_ok) begin
						len_valid_d = 1'b1;
						len_found_d = acc_q;
					end
					line_d = LINE_CLEAR;
					acc_d  = '0;
					if (!done) begin
						delim_d   = pend_cr_q ? 2'd1 : 2'd2;
						pend_cr_d = 1'b0;
					end else begin
						// header complete: start over on the header state
						delim_d     = 2'd0;
						has_bytes_d = 1'b0;
						pend_cr_d   = 1'b0;
						len_valid_d = 1'b0;
						len_found_d = '0;
						if (!(line_ok || len_valid_q)) begin
							emit      = 1'b1;
							emit_kind = RK_NO_LENGTH;
						end else if ((line_ok ? acc_q : len_found_q) == '0) begin
							emit      = 1'b1;
							emit_kind = RK_EMPTY;
						end else begin
							phase_d  = PH_BODY;
							remain_d = line_ok ? acc_q : len_found_q;
						end
					end
				end else if (byte_s1 == CH_CR) begin
					// hold this CR; a held one before it joins the line
					if (pend_cr_q) begin
						line_d  = line_cr;
						acc_d   = acc_cr;
						delim_d = 2'd0;
					end
					pend_cr_d = 1'b1;
				end else begin
					line_d    = line_ch;
					acc_d     = acc_ch;
					pend_cr_d = 1'b0;
					delim_d   = 2'd0;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.ready && feed.valid) begin
			kind_s1 <= feed.kind;
			byte_s1 <= feed.in_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= work && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			out_kind_q <= emit_kind;
			out_byte_q <= (emit_kind == RK_BODY) ? byte_s1 : 8'h00;
			out_last_q <= emit_last;
		end
	end

	// deframer state, advanced once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			delim_q     <= 2'd0;
			has_bytes_q <= 1'b0;
			pend_cr_q   <= 1'b0;
			line_q      <= LINE_CLEAR;
			acc_q       <= '0;
			len_valid_q <= 1'b0;
			len_found_q <= '0;
			remain_q    <= '0;
		end else if (work) begin
			phase_q     <= phase_d;
			delim_q     <= delim_d;
			has_bytes_q <= has_bytes_d;
			pend_cr_q   <= pend_cr_d;
			line_q      <= line_d;
			acc_q       <= acc_d;
			len_valid_q <= len_valid_d;
			len_found_q <= len_found_d;
			remain_q    <= remain_d;
		end
	end

	// a body phase always has bytes left to pass
	a_body_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (remain_q != '0))
		else $error("body phase with no bytes remaining");

	// once stopped, no new result appears
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP && !out_valid_q) |=> !out_valid_q)
		else $error("result produced after end of input");

	// the last mark only travels on body bytes
	a_last_on_body: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_kind_q == RK_BODY))
		else $error("last mark on a status result");

	// key matching never runs past the key text
	a_key_bound: assert property (@(posedge clk) disable iff (!arst_n)
		work |=> (line_q.key_pos <= KEY_LEN))
		else $error("key position beyond key length");

endmodule

>>> test/tb_top.sv
// Self-checking bench for content_length_message_deframer_core.
// Drives header/body byte streams with random idling, predicts every result beat.
// Depends on cld_pkg, cld_feed_if, cld_result_if and the core under test.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cld_pkg::*;

	localparam int          LEN_BITS = 31;
	localparam logic [63:0] LEN_MAX  = (64'd1 << LEN_BITS) - 64'd1;
	localparam int          ITEMS    = 1350;
	localparam string       KEY_TEXT = "Content-Length";

	typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_STOPPED} scan_phase_t;

	// one result beat as seen on the result channel
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
	} deframed_t;

	typedef struct {
		string     text;
		bit        typed;
		deframed_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cld_feed_if   feed ();
	cld_result_if result ();

	content_length_message_deframer_core #(
		.LENGTH_BITS(LEN_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.feed  (feed),
		.result(result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the header scanner.
	// ------------------------------------------------------------------
	scan_phase_t scan_phase;
	logic [1:0]  term_count;   // progress toward the blank line
	logic        hdr_seen;     // any byte of the current header received
	logic        cr_held;      // CR waiting to see whether LF follows
	logic [3:0]  key_idx;
	logic [1:0]  key_st;
	logic [2:0]  val_st;
	logic        val_neg;
	logic [63:0] val_acc;
	logic        len_ok;
	logic [63:0] len_val;
	logic [63:0] body_left;

	deframed_t deframed_q [$];  // result beats owed by the block, oldest first
	deframed_t due;

	int n_errors   = 0;
	int fed_count  = 0;
	bit calm_tail  = 1'b0;      // last part of the run: no idling on either side
	bit hold_req   = 1'b0;      // ask the receiver for one long hold-off
	int gap_rate   = 4;

	string LEAD_WS [5] = '{" ", "\t", "\013", "\014", "\015"};

	// Lines that never yield a valid length, wherever they sit in a header.
	string BAD_LINES [19] = '{
		"Content-Length: 12x",
		"Content-Length: -7",
		"Content-Length: 2147483648",
		"Content-Length: 99999999999",
		"Content-Length:",
		"Content-Length: +",
		"Content-Length: 4 5",
		"Content-Length: 3\t x",
		"Content-Length: 3\015x",
		"Content-Length:5:",
		"content-length: 3",
		"Content-Length : 3",
		"Content-LengthX: 3",
		"X-Content-Length: 3",
		"Content-Lengt: 3",
		"Content-Le\015ngth: 3",
		"Content-Length: --1",
		"Content-Length: 0x10",
		"Content-Type: application/json; charset=utf-8"
	};

	function automatic void reset_line();
		key_idx = 4'd0;
		key_st  = KS_MATCH;
		val_st  = VS_LEAD;
		val_neg = 1'b0;
		val_acc = 64'd0;
	endfunction

	function automatic void reset_header();
		term_count = 2'd0;
		hdr_seen   = 1'b0;
		cr_held    = 1'b0;
		len_ok     = 1'b0;
		len_val    = 64'd0;
		reset_line();
	endfunction

	// times-ten add; a value past the length range poisons the line
	function automatic void push_digit(input logic [7:0] c);
		logic [63:0] nxt;
		nxt = val_acc * 64'd10 + 64'(c - CH_ZERO);
		if (nxt > LEN_MAX)
			val_st = VS_FAIL;
		else begin
			val_acc = nxt;
			val_st  = VS_DIGITS;
		end
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		bit is_dig, is_blank;
		is_dig   = (c >= CH_ZERO && c <= CH_NINE);
		is_blank = (c == CH_SPACE || c == CH_TAB);
		if (key_st == KS_MATCH) begin
			if (key_idx >= KEY_LEN)
				key_st = (c == CH_COLON) ? KS_VALUE : KS_DEAD;
			else if (c == KEY_TEXT[key_idx])
				key_idx++;
			else
				key_st = KS_DEAD;
		end else if (key_st == KS_VALUE) begin
			case (val_st)
				VS_LEAD: begin
					if (c == CH_PLUS)
						val_st = VS_SIGN;
					else if (c == CH_MINUS) begin
						val_neg = 1'b1;
						val_st  = VS_SIGN;
					end else if (is_dig)
						push_digit(c);
					else if (!(is_blank || c == CH_VT || c == CH_FF || c == CH_CR))
						val_st = VS_FAIL;
				end
				VS_SIGN: begin
					if (is_dig) push_digit(c);
					else        val_st = VS_FAIL;
				end
				VS_DIGITS: begin
					if (is_dig)        push_digit(c);
					else if (is_blank) val_st = VS_TRAIL;
					else               val_st = VS_FAIL;
				end
				VS_TRAIL: begin
					if (!is_blank) val_st = VS_FAIL;
				end
				default: val_st = VS_FAIL;
			endcase
		end
	endfunction

	// end of a header line: keep the value if it parsed and is not negative
	function automatic void close_line();
		if (key_st == KS_VALUE && (val_st == VS_DIGITS || val_st == VS_TRAIL) &&
				!(val_neg && val_acc != 64'd0)) begin
			len_ok  = 1'b1;
			len_val = val_acc;
		end
		reset_line();
	endfunction

	// Advance the predictor by one accepted feed beat; return 1 when it owes a result.
	function automatic bit deframe_step(input logic k, input logic [7:0] c,
			output deframed_t r);
		bit          done, ok;
		logic [63:0] len;
		r = '0;
		if (scan_phase == SCAN_STOPPED)
			return 1'b0;
		if (k == KIND_END) begin
			if (scan_phase == SCAN_BODY) begin
				scan_phase = SCAN_STOPPED;
				r.kind = RK_TRUNC_BODY;
				return 1'b1;
			end
			scan_phase = SCAN_STOPPED;
			if (hdr_seen) begin
				r.kind = RK_TRUNC_HDR;
				return 1'b1;
			end
			return 1'b0;
		end
		if (scan_phase == SCAN_BODY) begin
			if (body_left != 64'd0)
				body_left--;
			r.kind = RK_BODY;
			r.data = c;
			if (body_left == 64'd0) begin
				r.last     = 1'b1;
				scan_phase = SCAN_HEADER;
			end
			return 1'b1;
		end
		hdr_seen = 1'b1;
		if (c == CH_LF) begin
			done = (!cr_held && term_count != 2'd0) || (cr_held && term_count == 2'd1);
			close_line();
			if (!done) begin
				term_count = cr_held ? 2'd1 : 2'd2;
				cr_held    = 1'b0;
				return 1'b0;
			end
			ok  = len_ok;
			len = len_val;
			reset_header();
			if (!ok) begin
				r.kind = RK_NO_LENGTH;
				return 1'b1;
			end
			if (len == 64'd0) begin
				r.kind = RK_EMPTY;
				return 1'b1;
			end
			scan_phase = SCAN_BODY;
			body_left  = len;
			return 1'b0;
		end
		if (c == CH_CR) begin
			// a second CR in a row: the first one was a lone CR, part of the line
			if (cr_held) begin
				scan_char(CH_CR);
				term_count = 2'd0;
			end
			cr_held = 1'b1;
			return 1'b0;
		end
		if (cr_held)
			scan_char(CH_CR);
		scan_char(c);
		cr_held    = 1'b0;
		term_count = 2'd0;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic int pick_rate();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 8;
		endcase
	endfunction

	// mostly keep the header's line-end style, sometimes mix it
	function automatic string eol_text(input bit crlf);
		if (crlf ^ ($urandom_range(0, 9) == 0))
			return "\015\n";
		return "\n";
	endfunction

	function automatic string filler_line();
		string s;
		s = "";
		if ($urandom_range(0, 1) == 0)
			return BAD_LINES[$urandom_range(0, 18)];
		repeat ($urandom_range(1, 16))
			s = $sformatf("%s%c", s, 8'($urandom_range(32, 255)));
		return s;
	endfunction

	// a valid length line with random blanks, sign and leading zeros
	function automatic string length_line(input int len);
		string s;
		s = "Content-Length:";
		repeat ($urandom_range(0, 2))
			s = {s, LEAD_WS[$urandom_range(0, 4)]};
		if (len == 0 && $urandom_range(0, 2) == 0)
			s = {s, "-"};
		else if ($urandom_range(0, 3) == 0)
			s = {s, "+"};
		if ($urandom_range(0, 4) == 0)
			s = {s, "00"};
		s = {s, $sformatf("%0d", len)};
		repeat ($urandom_range(0, 2))
			s = {s, LEAD_WS[$urandom_range(0, 1)]};
		return s;
	endfunction

	// Whole header up to the blank line. The length line, when present, is the
	// last valid one; earlier valid lines (up to the maximum) must lose to it.
	function automatic string header_text(input int len, input bit with_len,
			input bit allow_huge);
		string s;
		bit    crlf;
		crlf = $urandom_range(0, 1);
		s = "";
		repeat ($urandom_range(0, 2)) begin
			if (with_len && allow_huge && $urandom_range(0, 2) == 0)
				s = {s, $sformatf("Content-Length: %0d",
					$urandom_range(0, 1) ? LEN_MAX : 64'd9)};
			else
				s = {s, filler_line()};
			s = {s, eol_text(crlf)};
		end
		if (with_len)
			s = {s, length_line(len), eol_text(crlf)};
		repeat ($urandom_range(0, 2))
			s = {s, filler_line(), eol_text(crlf)};
		return {s, eol_text(crlf)};
	endfunction

	// ------------------------------------------------------------------
	// Feed side: drive one beat, wait for it to be taken, then predict.
	// ------------------------------------------------------------------
	task automatic feed_beat(input logic k, input logic [7:0] b,
			input bit use_want = 1'b0, input deframed_t want = '0);
		deframed_t r;
		bit        owed;
		if (!calm_tail && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
			feed.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		if ($urandom_range(0, 63) == 0)
			gap_rate = pick_rate();
		feed.valid   <= 1'b1;
		feed.kind    <= k;
		feed.in_byte <= b;
		do @(posedge clk); while (feed.ready !== 1'b1);
		owed = deframe_step(k, b, r);
		if (use_want)
			deframed_q = {deframed_q, want};
		else if (owed)
			deframed_q = {deframed_q, r};
		fed_count++;
		calm_tail = (fed_count >= ITEMS - 150);
	endtask

	task automatic feed_text(input string s);
		for (int i = 0; i < s.len(); i++)
			feed_beat(KIND_DATA, s[i]);
	endtask

	// ------------------------------------------------------------------
	// Main stimulus
	// ------------------------------------------------------------------
	initial begin
		dir_row_t dir_rows [4];
		string    txt;
		int       sel, len, msgs, cut;
		bit       press_armed;

		msgs        = 0;
		press_armed = 1'b0;
		scan_phase  = SCAN_HEADER;
		body_left   = 64'd0;
		reset_header();

		// Shortest headers first, then a one-byte body holding the top byte value.
		dir_rows[0] = '{text: "\n\n", typed: 1'b1, want: '{RK_NO_LENGTH, 8'h00, 1'b0}};
		dir_rows[1] = '{text: "\015\n\015\n", typed: 1'b1,
			want: '{RK_NO_LENGTH, 8'h00, 1'b0}};
		dir_rows[2] = '{text: "Content-Length:1\n\n", typed: 1'b0, want: '0};
		dir_rows[3] = '{text: "\377", typed: 1'b1, want: '{RK_BODY, 8'hFF, 1'b1}};

		arst_n       = 1'b0;
		feed.valid   <= 1'b0;
		feed.kind    <= KIND_DATA;
		feed.in_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			for (int i = 0; i < dir_rows[r].text.len(); i++)
				feed_beat(KIND_DATA, dir_rows[r].text[i],
					dir_rows[r].typed && i == dir_rows[r].text.len() - 1, dir_rows[r].want);

		// Random part: mostly well-formed messages, some length-less headers,
		// some headers cut short, some raw noise.
		while (1) begin
			// finish any body in progress; arm the long receiver hold on a long one
			while (scan_phase == SCAN_BODY) begin
				if (press_armed && body_left > 64'd20) begin
					hold_req    = 1'b1;
					press_armed = 1'b0;
				end
				feed_beat(KIND_DATA, 8'($urandom));
			end
			if (fed_count >= ITEMS)
				break;
			msgs++;
			// the pressure message always carries a long body
			sel = (msgs % 25 == 10) ? 0 : $urandom_range(0, 99);
			if (sel < 80) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: len = $urandom_range(0, 4);
					5, 6, 7, 8:    len = $urandom_range(5, 30);
					default:       len = $urandom_range(31, 80);
				endcase
				if (msgs % 25 == 10) begin
					len         = 40;
					press_armed = 1'b1;
				end
				feed_text(header_text(len, 1'b1, 1'b1));
			end else if (sel < 88) begin
				feed_text(header_text(0, 1'b0, 1'b0));
			end else if (sel < 94) begin
				txt = header_text($urandom_range(0, 8), 1'b1, 1'b0);
				cut = $urandom_range(1, txt.len() - 1);
				feed_text(txt.substr(0, cut - 1));
			end else begin
				repeat ($urandom_range(1, 20))
					feed_beat(KIND_DATA, 8'($urandom));
			end
		end

		// End of input lands between messages, inside a header or inside a body.
		case ($urandom_range(0, 2))
			0: begin
			end
			1: begin
				feed_text("Content-Length: 5\n\n");
				feed_beat(KIND_DATA, 8'($urandom));
			end
			default: feed_text("Content-");
		endcase
		feed_beat(KIND_END, 8'($urandom));
		// the block is stopped now: these beats must vanish
		repeat (4)
			feed_beat(1'($urandom), 8'($urandom));
		feed.valid <= 1'b0;

		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus one long hold-off on request.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int stall_rate;
		stall_left = 0;
		stall_rate = 6;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = 150;
			end
			if ($urandom_range(0, 63) == 0)
				stall_rate = pick_rate();
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (!calm_tail && stall_rate != 0 &&
					$urandom_range(1, stall_rate) == 1) begin
				stall_left = $urandom_range(0, 10);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Compare each taken result beat against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (deframed_q.size() == 0) begin
				$error("unexpected result beat: kind %0d byte %02h last %0d",
					result.result_kind, result.out_byte, result.last_of_message);
				n_errors++;
			end else begin
				due = deframed_q.pop_front();
				if (result.result_kind !== due.kind) begin
					$error("result_kind: expected %0d, got %0d", due.kind, result.result_kind);
					n_errors++;
				end
				if (result.out_byte !== due.data) begin
					$error("out_byte: expected %02h, got %02h", due.data, result.out_byte);
					n_errors++;
				end
				if (result.last_of_message !== due.last) begin
					$error("last_of_message: expected %0d, got %0d", due.last,
						result.last_of_message);
					n_errors++;
				end
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
